### rtl/box_non_maximum_suppression_unit_defines.svh
// Assertion helpers shared by the RTL of the box suppression unit.
// Each macro names the assertion, the clock, the active low reset, the
// condition that triggers the check, the expected consequence and a message.
`ifndef BOX_NON_MAXIMUM_SUPPRESSION_UNIT_DEFINES_SVH
`define BOX_NON_MAXIMUM_SUPPRESSION_UNIT_DEFINES_SVH

// Consequence must hold in the same cycle as the trigger.
`define BNMS_ASSERT_SAME(label, clk, rst_n, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
		else $error(msg);

// Consequence must hold in the cycle after the trigger.
`define BNMS_ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

### rtl/bnms_pkg.sv
// ----------------------------------------------------------------------------
// bnms_pkg
// Shared types and constants of the box suppression unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bnms_pkg;

	localparam int MaxBoxesDefault = 64;
	localparam int SlotW           = 6;
	localparam logic [15:0] IouThresholdReset = 16'd3277;

	// One stored box as kept in the box memory.
	typedef struct packed {
		logic signed [17:0] left;
		logic signed [17:0] top;
		logic [15:0]        width;
		logic [15:0]        height;
		logic [15:0]        score;
		logic [7:0]         class_tag;
	} box_t;

	// The box that currently scans the later boxes, in edge form.
	typedef struct packed {
		logic signed [18:0] left;
		logic signed [18:0] top;
		logic signed [18:0] right;
		logic signed [18:0] bottom;
		logic [31:0]        area;
		logic [15:0]        score;
	} ibox_t;

	// Verdict of the overlap pipeline on one pair.
	typedef struct packed {
		logic        valid;
		logic        overlap;
		logic [15:0] score;
	} verdict_t;

endpackage

`default_nettype wire

### rtl/bnms_box_mem.sv
// ----------------------------------------------------------------------------
// bnms_box_mem
// Box store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bnms_box_mem
	import bnms_pkg::*;
#(
	parameter int DEPTH = MaxBoxesDefault,
	parameter int IDX_W = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [IDX_W-1:0] waddr,
	input  wire box_t             wdata,
	input  wire logic [IDX_W-1:0] raddr,
	output box_t                  rdata
);

	box_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### rtl/bnms_iou_pipe.sv
// ----------------------------------------------------------------------------
// bnms_iou_pipe
// Six stage overlap test of the scanning box against one later box per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bnms_iou_pipe
	import bnms_pkg::*;
#(
	parameter int IDX_W = 6
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             flush,
	input  wire logic [15:0]      thr,
	input  wire ibox_t            bi,
	input  wire logic             v_s1,
	input  wire logic [IDX_W-1:0] j_s1,
	input  wire box_t             bj_s1,
	output verdict_t              verdict,
	output logic [IDX_W-1:0]      verdict_j,
	output logic                  busy
);

	logic signed [18:0] lj, tj, rj, bj;
	logic signed [18:0] x1_d, x2_d, y1_d, y2_d;

	logic v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [IDX_W-1:0] j_s2, j_s3, j_s4, j_s5, j_s6;
	logic [15:0] s_s2, s_s3, s_s4, s_s5, s_s6;
	logic signed [18:0] x1_s2, x2_s2, y1_s2, y2_s2;
	logic [15:0] w_s2, h_s2, w_s3, h_s3, iw_s3, ih_s3;
	logic [31:0] inter_s4, aj_s4, inter_s5, inter_s6;
	logic [32:0] sum_d, uni_s5;
	logic uok_s5, uok_s6;
	logic [48:0] prod_s6;

	assign lj = 19'(bj_s1.left);
	assign tj = 19'(bj_s1.top);
	assign rj = lj + $signed({3'b000, bj_s1.width});
	assign bj = tj + $signed({3'b000, bj_s1.height});

	assign x1_d = (bi.left > lj) ? bi.left : lj;
	assign x2_d = (bi.right < rj) ? bi.right : rj;
	assign y1_d = (bi.top > tj) ? bi.top : tj;
	assign y2_d = (bi.bottom < bj) ? bi.bottom : bj;

	assign sum_d = {1'b0, bi.area} + {1'b0, aj_s4};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s2 <= v_s1 && !flush;
			v_s3 <= v_s2 && !flush;
			v_s4 <= v_s3 && !flush;
			v_s5 <= v_s4 && !flush;
			v_s6 <= v_s5 && !flush;
		end
	end

	always_ff @(posedge clk) begin
		j_s2  <= j_s1;
		s_s2  <= bj_s1.score;
		w_s2  <= bj_s1.width;
		h_s2  <= bj_s1.height;
		x1_s2 <= x1_d;
		x2_s2 <= x2_d;
		y1_s2 <= y1_d;
		y2_s2 <= y2_d;

		j_s3  <= j_s2;
		s_s3  <= s_s2;
		w_s3  <= w_s2;
		h_s3  <= h_s2;
		iw_s3 <= (x2_s2 > x1_s2) ? 16'(x2_s2 - x1_s2) : 16'd0;
		ih_s3 <= (y2_s2 > y1_s2) ? 16'(y2_s2 - y1_s2) : 16'd0;

		j_s4     <= j_s3;
		s_s4     <= s_s3;
		inter_s4 <= 32'(iw_s3) * 32'(ih_s3);
		aj_s4    <= 32'(w_s3) * 32'(h_s3);

		j_s5     <= j_s4;
		s_s5     <= s_s4;
		inter_s5 <= inter_s4;
		uok_s5   <= sum_d > {1'b0, inter_s4};
		uni_s5   <= sum_d - {1'b0, inter_s4};

		j_s6     <= j_s5;
		s_s6     <= s_s5;
		inter_s6 <= inter_s5;
		uok_s6   <= uok_s5;
		prod_s6  <= 49'(thr) * 49'(uni_s5);
	end

	assign verdict.valid   = v_s6;
	assign verdict.overlap = uok_s6 && ({1'b0, inter_s6, 16'd0} > prod_s6);
	assign verdict.score   = s_s6;
	assign verdict_j       = j_s6;
	assign busy            = v_s2 || v_s3 || v_s4 || v_s5;

endmodule

`default_nettype wire

### rtl/box_non_maximum_suppression_unit.sv
// ----------------------------------------------------------------------------
// box_non_maximum_suppression_unit
// Loads a list of boxes, suppresses overlapping ones greedily, emits survivors.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake            Content
// in        into       in_valid/in_stall    one box per item, final_box ends list
// out       out of     out_valid/out_stall  one surviving box per item
// cfg       into       cfg_valid/cfg_ready  IoU threshold
//
// Boxes are loaded while in_stall is low. After the final box, each kept box i
// is fetched from the box memory through S_ISEL and S_IWAIT, then scans the
// later boxes at one pair per cycle through a six stage overlap pipeline,
// which drains, or is flushed when the scanning box is dropped, before the
// next kept box is fetched. Each survivor is then read and presented through
// S_ESEL, S_EWAIT and S_EHOLD, which waits while out_stall is high. Reset
// clears the list; the box memory needs no clearing. No box is taken while a list is being suppressed or emitted.
`default_nettype none

module box_non_maximum_suppression_unit
	import bnms_pkg::*;
#(
	parameter int MAX_BOXES = MaxBoxesDefault
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [17:0] box_left,
	input  wire logic signed [17:0] box_top,
	input  wire logic [15:0]        box_width,
	input  wire logic [15:0]        box_height,
	input  wire logic [15:0]        score,
	input  wire logic [7:0]         class_tag,
	input  wire logic               final_box,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [SlotW-1:0]        slot,
	output logic signed [17:0]      out_left,
	output logic signed [17:0]      out_top,
	output logic [15:0]             out_width,
	output logic [15:0]             out_height,
	output logic [15:0]             out_score,
	output logic [7:0]              out_class,
	output logic                    run_end,
	output logic                    none_kept,
	output logic                    overflowed,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [15:0]        cfg_data
);

`include "box_non_maximum_suppression_unit_defines.svh"

	localparam int IDX_W = $clog2(MAX_BOXES);
	localparam int CNT_W = $clog2(MAX_BOXES + 1);
	localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_BOXES);

	typedef enum logic [2:0] {
		S_LOAD, S_ISEL, S_IWAIT, S_SCAN, S_ESEL, S_EWAIT, S_EHOLD
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   count_q, i_q, j_q, k_q;
	logic               ovf_q, emitted_q;
	logic [MAX_BOXES-1:0] keep_q;
	logic [15:0]        thr_q;
	ibox_t              bi_q;
	logic               iss_v_s1;
	logic [IDX_W-1:0]   iss_j_s1;

	logic               in_acc, store, issue, drop_i, drop_j, busy, any_above;
	logic [CNT_W-1:0]   n_next;
	logic [IDX_W-1:0]   raddr;
	box_t               wbox, rbox;
	verdict_t           verdict;
	logic [IDX_W-1:0]   verdict_j;
	logic [MAX_BOXES-1:0] above;

	// The threshold register; the user must make writes only while no list is in flight; the block does not enforce this.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= IouThresholdReset;
		end else if (cfg_valid && cfg_ready) begin
			thr_q <= cfg_data;
		end
	end

	assign in_stall = (state_q != S_LOAD);
	assign in_acc   = in_valid && !in_stall;
	assign store    = in_acc && (count_q < CAP);
	assign n_next   = store ? count_q + CNT_W'(1) : count_q;

	assign wbox.left      = box_left;
	assign wbox.top       = box_top;
	assign wbox.width     = box_width;
	assign wbox.height    = box_height;
	assign wbox.score     = score;
	assign wbox.class_tag = class_tag;

	// A single read port serves fetching the scanning box, the scanned boxes
	// and the survivors during emission.
	always_comb begin
		case (state_q)
			S_ISEL:  raddr = i_q[IDX_W-1:0];
			S_ESEL:  raddr = k_q[IDX_W-1:0];
			default: raddr = j_q[IDX_W-1:0];
		endcase
	end

	bnms_box_mem #(
		.DEPTH(MAX_BOXES),
		.IDX_W(IDX_W)
	) u_mem (
		.clk   (clk),
		.we    (store),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (wbox),
		.raddr (raddr),
		.rdata (rbox)
	);

	bnms_iou_pipe #(
		.IDX_W(IDX_W)
	) u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.flush     (drop_i),
		.thr       (thr_q),
		.bi        (bi_q),
		.v_s1      (iss_v_s1),
		.j_s1      (iss_j_s1),
		.bj_s1     (rbox),
		.verdict   (verdict),
		.verdict_j (verdict_j),
		.busy      (busy)
	);

	// An overlapping later box is dropped when the scanning box scores
	// strictly higher; otherwise the scanning box itself is dropped, the
	// rest of its scan is flushed and the next kept box takes over.
	assign drop_j = verdict.valid && verdict.overlap && (bi_q.score > verdict.score);
	assign drop_i = verdict.valid && verdict.overlap && !(bi_q.score > verdict.score);
	assign issue  = (state_q == S_SCAN) && (j_q < count_q) && !drop_i;

	// Whether any kept box lies after the one being emitted decides run_end.
	always_comb begin
		for (int b = 0; b < MAX_BOXES; b++) begin
			above[b] = keep_q[b] && (CNT_W'(b) > k_q);
		end
	end
	assign any_above = |above;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_LOAD;
			count_q    <= '0;
			i_q        <= '0;
			j_q        <= '0;
			k_q        <= '0;
			ovf_q      <= 1'b0;
			emitted_q  <= 1'b0;
			keep_q     <= '0;
			iss_v_s1   <= 1'b0;
			iss_j_s1   <= '0;
			bi_q       <= '0;
			out_valid  <= 1'b0;
			slot       <= '0;
			out_left   <= '0;
			out_top    <= '0;
			out_width  <= '0;
			out_height <= '0;
			out_score  <= '0;
			out_class  <= '0;
			run_end    <= 1'b0;
			none_kept  <= 1'b0;
			overflowed <= 1'b0;
		end else begin
			iss_v_s1 <= 1'b0;
			case (state_q)
				S_LOAD: begin
					if (store) begin
						keep_q[count_q[IDX_W-1:0]] <= 1'b1;
					end
					if (in_acc && !store) begin
						ovf_q <= 1'b1;
					end
					count_q <= n_next;
					if (in_acc && final_box) begin
						i_q       <= '0;
						k_q       <= '0;
						emitted_q <= 1'b0;
						state_q   <= (n_next >= CNT_W'(2)) ? S_ISEL : S_ESEL;
					end
				end
				S_ISEL: begin
					if (i_q == count_q) begin
						state_q <= S_ESEL;
					end else if (!keep_q[i_q[IDX_W-1:0]]) begin
						i_q <= i_q + CNT_W'(1);
					end else begin
						state_q <= S_IWAIT;
					end
				end
				S_IWAIT: begin
					bi_q.left   <= 19'(rbox.left);
					bi_q.top    <= 19'(rbox.top);
					bi_q.right  <= 19'(rbox.left) + $signed({3'b000, rbox.width});
					bi_q.bottom <= 19'(rbox.top) + $signed({3'b000, rbox.height});
					bi_q.area   <= 32'(rbox.width) * 32'(rbox.height);
					bi_q.score  <= rbox.score;
					j_q         <= i_q + CNT_W'(1);
					state_q     <= S_SCAN;
				end
				S_SCAN: begin
					if (drop_j) begin
						keep_q[verdict_j] <= 1'b0;
					end
					if (drop_i) begin
						keep_q[i_q[IDX_W-1:0]] <= 1'b0;
						i_q     <= i_q + CNT_W'(1);
						state_q <= S_ISEL;
					end else if (issue) begin
						iss_v_s1 <= keep_q[j_q[IDX_W-1:0]];
						iss_j_s1 <= j_q[IDX_W-1:0];
						j_q      <= j_q + CNT_W'(1);
					end else if (!iss_v_s1 && !busy) begin
						i_q     <= i_q + CNT_W'(1);
						state_q <= S_ISEL;
					end
				end
				S_ESEL: begin
					if (k_q == count_q) begin
						if (!emitted_q) begin
							out_valid  <= 1'b1;
							slot       <= '0;
							out_left   <= '0;
							out_top    <= '0;
							out_width  <= '0;
							out_height <= '0;
							out_score  <= '0;
							out_class  <= '0;
							run_end    <= 1'b1;
							none_kept  <= 1'b1;
							overflowed <= ovf_q;
							state_q    <= S_EHOLD;
						end else begin
							keep_q  <= '0;
							count_q <= '0;
							ovf_q   <= 1'b0;
							state_q <= S_LOAD;
						end
					end else if (!keep_q[k_q[IDX_W-1:0]]) begin
						k_q <= k_q + CNT_W'(1);
					end else begin
						state_q <= S_EWAIT;
					end
				end
				S_EWAIT: begin
					out_valid  <= 1'b1;
					slot       <= SlotW'(k_q);
					out_left   <= rbox.left;
					out_top    <= rbox.top;
					out_width  <= rbox.width;
					out_height <= rbox.height;
					out_score  <= rbox.score;
					out_class  <= rbox.class_tag;
					run_end    <= !any_above;
					none_kept  <= 1'b0;
					overflowed <= ovf_q;
					emitted_q  <= 1'b1;
					state_q    <= S_EHOLD;
				end
				S_EHOLD: begin
					if (out_valid && !out_stall) begin
						out_valid <= 1'b0;
						if (run_end) begin
							keep_q  <= '0;
							count_q <= '0;
							ovf_q   <= 1'b0;
							state_q <= S_LOAD;
						end else begin
							k_q     <= k_q + CNT_W'(1);
							state_q <= S_ESEL;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	// Results are never shown while a list is still loading.
	`BNMS_ASSERT_SAME(a_no_out_in_load, clk, arst_n, state_q == S_LOAD, !out_valid,
		"result during load")
	// Pair verdicts only arrive while a scan is running.
	`BNMS_ASSERT_SAME(a_verdict_in_scan, clk, arst_n, verdict.valid, state_q == S_SCAN,
		"stray verdict")
	// Delivering the last result of a list empties the list state.
	`BNMS_ASSERT_NEXT(a_list_cleared, clk, arst_n, out_valid && !out_stall && run_end,
		(count_q == '0) && !ovf_q && (keep_q == '0), "list not cleared")

endmodule

`default_nettype wire
